>>> sv/cpeh_pkg.sv
// Package for the circle/polygon edge hit unit: widths and beat types.
// No dependencies; used by the top level and the bench.
package cpeh_pkg;

    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 8;
    localparam int VTX_BITS   = COORD_BITS + 1;
    localparam int DIF_BITS   = COORD_BITS + 2;
    localparam int MAG_BITS   = DIF_BITS - 1;
    localparam int PRD_BITS   = 2 * MAG_BITS;
    localparam int ACC_BITS   = PRD_BITS + 2;
    localparam int BIG_BITS   = 2 * ACC_BITS;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] wall_x;
        logic signed [COORD_BITS-1:0] wall_y;
        logic signed [COORD_BITS-1:0] circle_x;
        logic signed [COORD_BITS-1:0] circle_y;
        logic [COORD_BITS-2:0]        circle_radius;
        logic                         first_point;
        logic                         last_point;
        logic                         query_end;
    } vtx_beat_t;

    typedef struct packed {
        logic edge_hit;
        logic hit_so_far;
        logic result_last;
    } hit_beat_t;

endpackage

>>> sv/cpeh_stream_if.sv
// Valid/ready channel carrying one beat of type beat_t.
// No dependencies; the bench sets beat_t to the cpeh_pkg beat types.
interface cpeh_stream_if #(parameter type beat_t = logic);
    logic  valid;
    logic  ready;
    beat_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/circle_polygon_edge_hit_unit.sv
// Top level of the circle/polygon edge hit unit with its sequencer and shared multiplier.
// Depends on cpeh_pkg and cpeh_stream_if.
//
//  channel   direction  beat        contents
//  vtx       in         vtx_beat_t  vertex, wall offset, circle, polygon marks
//  hit       out        hit_beat_t  edge hit, running hit, query end
//
// Each vertex beat runs 22 sequencer steps for each edge it tests: none, one
// or two. A single shared 26x26 multiplier does all the work: 13 products
// per edge, then 7 partial products for the exact tangent comparison. Reset
// clears the stored first and previous vertices, the running hit and the
// sequencer. A new vertex is taken whenever the sequencer is idle; a finished
// result waits in the done state only while the output register still holds
// a beat that has not been taken.
module circle_polygon_edge_hit_unit
    import cpeh_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    cpeh_stream_if.sink                vtx,
    cpeh_stream_if.source              hit
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_MUL = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;
    localparam logic [4:0] LAST_STEP = 5'd21;

    logic [2:0] state_reg, state_next;
    logic [4:0] step_reg;
    logic       second_reg;         // working on the closing edge

    vtx_beat_t beat_reg;
    logic signed [VTX_BITS-1:0] vx_reg, vy_reg, fvx_reg, fvy_reg, pvx_reg, pvy_reg;
    logic signed [VTX_BITS-1:0] ex_p, ey_p, ex_q, ey_q;
    logic signed [DIF_BITS-1:0] lx_reg, ly_reg, fx_reg, fy_reg, gx_reg, gy_reg;
    logic [COORD_BITS-2:0] r_reg;
    logic signed [ACC_BITS-1:0] d0_reg, d1_reg, rr_reg, dot0_reg, dot1_reg, cr_reg, ll_reg;
    logic signed [BIG_BITS-1:0] big_reg;
    logic       hit_reg, any_reg;
    logic       out_valid_reg;
    hit_beat_t  out_reg;

    // Limbs for the tangent test: cr^2 - rr*ll is built from 26-bit halves.
    logic [ACC_BITS-1:0] cr_mag;
    logic [DIF_BITS-1:0] cr_hi, cr_lo, rr_hi, rr_lo, ll_hi, ll_lo;
    assign cr_mag = cr_reg[ACC_BITS-1] ? ACC_BITS'(-cr_reg) : ACC_BITS'(cr_reg);
    assign cr_hi  = cr_mag[ACC_BITS-1:DIF_BITS];
    assign cr_lo  = cr_mag[DIF_BITS-1:0];
    assign rr_hi  = rr_reg[ACC_BITS-1:DIF_BITS];
    assign rr_lo  = rr_reg[DIF_BITS-1:0];
    assign ll_hi  = ll_reg[ACC_BITS-1:DIF_BITS];
    assign ll_lo  = ll_reg[DIF_BITS-1:0];

    // Shared multiplier: signed steps multiply magnitudes and apply the sign after,
    // the tangent steps multiply unsigned limbs.
    logic signed [DIF_BITS-1:0] ma, mb;
    logic [DIF_BITS-1:0] big_a, big_b;
    logic use_big;
    logic [MAG_BITS-1:0] ma_mag, mb_mag;
    logic [DIF_BITS-1:0] mul_a, mul_b;
    logic [ACC_BITS-1:0] m_prod;
    logic signed [ACC_BITS-1:0] m_sprod;
    logic [BIG_BITS-1:0] big_prod;
    logic m_neg;

    always_comb
    begin
        ma = '0;
        mb = '0;
        big_a = '0;
        big_b = '0;
        use_big = 1'b0;
        unique case (step_reg)
            5'd1: begin ma = fx_reg; mb = fx_reg; end
            5'd2: begin ma = fy_reg; mb = fy_reg; end
            5'd3: begin ma = gx_reg; mb = gx_reg; end
            5'd4: begin ma = gy_reg; mb = gy_reg; end
            5'd5: begin ma = DIF_BITS'($signed({1'b0, r_reg})); mb = DIF_BITS'($signed({1'b0, r_reg})); end
            5'd6: begin ma = lx_reg; mb = fx_reg; end
            5'd7: begin ma = ly_reg; mb = fy_reg; end
            5'd8: begin ma = lx_reg; mb = gx_reg; end
            5'd9: begin ma = ly_reg; mb = gy_reg; end
            5'd10: begin ma = lx_reg; mb = fy_reg; end
            5'd11: begin ma = ly_reg; mb = fx_reg; end
            5'd12: begin ma = lx_reg; mb = lx_reg; end
            5'd13: begin ma = ly_reg; mb = ly_reg; end
            5'd14: begin use_big = 1'b1; big_a = cr_hi; big_b = cr_hi; end
            5'd15: begin use_big = 1'b1; big_a = cr_hi; big_b = cr_lo; end
            5'd16: begin use_big = 1'b1; big_a = cr_lo; big_b = cr_lo; end
            5'd17: begin use_big = 1'b1; big_a = rr_hi; big_b = ll_hi; end
            5'd18: begin use_big = 1'b1; big_a = rr_hi; big_b = ll_lo; end
            5'd19: begin use_big = 1'b1; big_a = rr_lo; big_b = ll_hi; end
            5'd20: begin use_big = 1'b1; big_a = rr_lo; big_b = ll_lo; end
            default: ;
        endcase
    end

    assign ma_mag   = ma[DIF_BITS-1] ? MAG_BITS'(-ma) : MAG_BITS'(ma);
    assign mb_mag   = mb[DIF_BITS-1] ? MAG_BITS'(-mb) : MAG_BITS'(mb);
    assign mul_a    = use_big ? big_a : {1'b0, ma_mag};
    assign mul_b    = use_big ? big_b : {1'b0, mb_mag};
    assign m_prod   = ACC_BITS'(mul_a) * ACC_BITS'(mul_b);
    assign m_neg    = ma[DIF_BITS-1] ^ mb[DIF_BITS-1];
    assign m_sprod  = m_neg ? -$signed(m_prod) : $signed(m_prod);
    assign big_prod = BIG_BITS'(m_prod);

    // Edge endpoints for the edge in work.
    always_comb
    begin
        if (second_reg)
        begin
            ex_p = vx_reg; ey_p = vy_reg; ex_q = fvx_reg; ey_q = fvy_reg;
        end
        else
        begin
            ex_p = pvx_reg; ey_p = pvy_reg; ex_q = vx_reg; ey_q = vy_reg;
        end
    end

    // The tangent test passes when cr^2 - rr*ll, held in big_reg, is not positive.
    logic zero_len, both_in, inner, edge_res;
    assign zero_len = (lx_reg == '0) && (ly_reg == '0);
    assign both_in  = (d0_reg < rr_reg) && (d1_reg < rr_reg);
    assign inner    = (dot0_reg <= 0) && (dot1_reg >= 0);
    assign edge_res = !zero_len && !both_in &&
                      (inner ? (big_reg[BIG_BITS-1] || (big_reg == '0))
                             : ((d0_reg <= rr_reg) || (d1_reg <= rr_reg)));

    logic need_first;
    assign need_first = !beat_reg.first_point;

    // The result is written once the output register is empty or being emptied.
    logic out_free, out_load;
    assign out_free = !out_valid_reg || hit.ready;
    assign out_load = (state_reg == ST_DONE) && out_free;

    assign vtx.ready = (state_reg == ST_IDLE);
    assign hit.valid = out_valid_reg;
    assign hit.data  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (vtx.valid && vtx.ready) state_next = ST_SETUP;
            ST_SETUP: state_next = (need_first || beat_reg.last_point) ? ST_MUL : ST_DONE;
            ST_MUL:   if (step_reg == LAST_STEP && (second_reg || !beat_reg.last_point))
                          state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg <= '0;
            second_reg <= 1'b0;
            fvx_reg <= '0; fvy_reg <= '0; pvx_reg <= '0; pvy_reg <= '0;
            any_reg <= 1'b0;
            hit_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (hit.valid && hit.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (vtx.valid && vtx.ready)
                    begin
                        beat_reg <= vtx.data;
                        vx_reg <= VTX_BITS'(vtx.data.point_x) + VTX_BITS'(vtx.data.wall_x);
                        vy_reg <= VTX_BITS'(vtx.data.point_y) + VTX_BITS'(vtx.data.wall_y);
                        r_reg <= vtx.data.circle_radius;
                        hit_reg <= 1'b0;
                    end
                end
                ST_SETUP:
                begin
                    second_reg <= !need_first;
                    step_reg <= '0;
                    if (beat_reg.first_point)
                    begin
                        fvx_reg <= vx_reg;
                        fvy_reg <= vy_reg;
                    end
                end
                ST_MUL:
                begin
                    if (step_reg == 5'd0)
                    begin
                        // Load edge operands once at the start of each edge.
                        lx_reg <= DIF_BITS'(ex_q) - DIF_BITS'(ex_p);
                        ly_reg <= DIF_BITS'(ey_q) - DIF_BITS'(ey_p);
                        fx_reg <= DIF_BITS'(ex_p) - DIF_BITS'(beat_reg.circle_x);
                        fy_reg <= DIF_BITS'(ey_p) - DIF_BITS'(beat_reg.circle_y);
                        gx_reg <= DIF_BITS'(ex_q) - DIF_BITS'(beat_reg.circle_x);
                        gy_reg <= DIF_BITS'(ey_q) - DIF_BITS'(beat_reg.circle_y);
                    end
                    unique case (step_reg)
                        5'd1:  d0_reg <= m_sprod;
                        5'd2:  d0_reg <= d0_reg + m_sprod;
                        5'd3:  d1_reg <= m_sprod;
                        5'd4:  d1_reg <= d1_reg + m_sprod;
                        5'd5:  rr_reg <= m_sprod;
                        5'd6:  dot0_reg <= m_sprod;
                        5'd7:  dot0_reg <= dot0_reg + m_sprod;
                        5'd8:  dot1_reg <= m_sprod;
                        5'd9:  dot1_reg <= dot1_reg + m_sprod;
                        5'd10: cr_reg <= m_sprod;
                        5'd11: cr_reg <= cr_reg - m_sprod;
                        5'd12: ll_reg <= m_sprod;
                        5'd13: ll_reg <= ll_reg + m_sprod;
                        5'd14: big_reg <= $signed(big_prod << (2 * DIF_BITS));
                        5'd15: big_reg <= big_reg + $signed(big_prod << (DIF_BITS + 1));
                        5'd16: big_reg <= big_reg + $signed(big_prod);
                        5'd17: big_reg <= big_reg - $signed(big_prod << (2 * DIF_BITS));
                        5'd18: big_reg <= big_reg - $signed(big_prod << DIF_BITS);
                        5'd19: big_reg <= big_reg - $signed(big_prod << DIF_BITS);
                        5'd20: big_reg <= big_reg - $signed(big_prod);
                        5'd21: if (edge_res) hit_reg <= 1'b1;
                        default: ;
                    endcase
                    if (step_reg == LAST_STEP && !second_reg && beat_reg.last_point)
                    begin
                        second_reg <= 1'b1;
                        step_reg <= '0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        pvx_reg <= vx_reg;
                        pvy_reg <= vy_reg;
                        out_reg.edge_hit <= hit_reg;
                        out_reg.hit_so_far <= any_reg | hit_reg;
                        out_reg.result_last <= beat_reg.query_end;
                        any_reg <= beat_reg.query_end ? 1'b0 : (any_reg | hit_reg);
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

>>> verif/tb_circle_polygon_edge_hit_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for circle_polygon_edge_hit_unit: vertex streams in, hit beats checked.
// Depends on cpeh_pkg, cpeh_stream_if and the unit's RTL.
module tb_circle_polygon_edge_hit_unit;
    import cpeh_pkg::*;

    // Exact products need about 100 bits; 160 leaves margin for signed sums.
    typedef logic signed [159:0] wide_t;

    logic clk;
    logic rst_n;

    cpeh_stream_if #(.beat_t(vtx_beat_t)) vtx ();
    cpeh_stream_if #(.beat_t(hit_beat_t)) hit ();

    circle_polygon_edge_hit_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .vtx   (vtx),
        .hit   (hit)
    );

    // Items still to be offered, and the hit beats that accepted items must produce.
    vtx_beat_t vertex_queue[$];
    hit_beat_t expected_hits[$];

    // Predictor state: the polygon's first vertex, the last vertex seen, the running hit.
    wide_t start_x, start_y, prev_x, prev_y;
    logic  running_hit;

    int  errors;
    int  cycle_count;
    bit  stimulus_done;
    bit  calm_phase;       // no random idling while set
    bit  hold_off;         // receiver stall, timed in its own process

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Decides whether the edge from (px,py) to (qx,qy) touches the circle boundary.
    // All arithmetic is exact in wide signed integers, so no rounding enters the decision.
    function automatic bit edge_touches(wide_t px, wide_t py, wide_t qx, wide_t qy,
                                        wide_t cx, wide_t cy, wide_t rad);
        wide_t lx, ly, fx, fy, gx, gy, d0, d1, rr, dot0, dot1, crs;
        lx = qx - px;
        ly = qy - py;
        fx = px - cx;
        fy = py - cy;
        gx = qx - cx;
        gy = qy - cy;
        // A degenerate edge cannot reach the boundary.
        if (lx == 0 && ly == 0)
            return 1'b0;
        d0 = fx * fx + fy * fy;
        d1 = gx * gx + gy * gy;
        rr = rad * rad;
        // Both ends strictly inside the circle: the whole edge is inside.
        if (d0 < rr && d1 < rr)
            return 1'b0;
        dot0 = lx * fx + ly * fy;
        dot1 = lx * gx + ly * gy;
        // The closest point lies on the edge: compare its distance with the radius.
        if (dot0 <= 0 && dot1 >= 0)
        begin
            crs = lx * fy - ly * fx;
            return (crs * crs) <= rr * (lx * lx + ly * ly);
        end
        return d0 <= rr || d1 <= rr;
    endfunction

    // Works out the hit beat for one accepted vertex and advances the predictor.
    function automatic hit_beat_t predict_hit(vtx_beat_t v);
        hit_beat_t res;
        wide_t vx, vy, cx, cy, rad;
        bit touched;
        vx = wide_t'(v.point_x) + wide_t'(v.wall_x);
        vy = wide_t'(v.point_y) + wide_t'(v.wall_y);
        cx = wide_t'(v.circle_x);
        cy = wide_t'(v.circle_y);
        rad = wide_t'({1'b0, v.circle_radius});
        touched = 1'b0;
        if (v.first_point)
        begin
            start_x = vx;
            start_y = vy;
        end
        else if (edge_touches(prev_x, prev_y, vx, vy, cx, cy, rad))
            touched = 1'b1;
        // The last vertex also closes the polygon back to its first vertex.
        if (v.last_point && edge_touches(vx, vy, start_x, start_y, cx, cy, rad))
            touched = 1'b1;
        prev_x = vx;
        prev_y = vy;
        running_hit = running_hit | touched;
        res.edge_hit = touched;
        res.hit_so_far = running_hit;
        res.result_last = v.query_end;
        if (v.query_end)
            running_hit = 1'b0;
        return res;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        logic signed [COORD_BITS-1:0] c;
        c = COORD_BITS'($urandom);
        return c;
    endfunction

    // A coordinate near a centre, so that edges pass close to the circle and
    // hits and misses both occur often.
    function automatic logic signed [COORD_BITS-1:0] near_coord(int centre, int spread);
        return COORD_BITS'(centre + $signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // One polygon of n random vertices around (cx,cy), offset by a random wall.
    task automatic add_polygon(int n, int cx, int cy, int rad, bit end_query);
        vtx_beat_t v;
        int wx, wy, spread;
        wx = $signed($urandom_range(0, 2000)) - 1000;
        wy = $signed($urandom_range(0, 2000)) - 1000;
        spread = rad * 2 + 16;
        for (int i = 0; i < n; i++)
        begin
            v.point_x = near_coord(cx - wx, spread);
            v.point_y = near_coord(cy - wy, spread);
            v.wall_x = COORD_BITS'(wx);
            v.wall_y = COORD_BITS'(wy);
            v.circle_x = COORD_BITS'(cx);
            v.circle_y = COORD_BITS'(cy);
            v.circle_radius = (COORD_BITS-1)'(rad);
            v.first_point = (i == 0);
            v.last_point = (i == n - 1);
            v.query_end = end_query && (i == n - 1);
            vertex_queue.push_back(v);
        end
    endtask

    function automatic vtx_beat_t make_vertex(int px, int py, int wx, int wy, int cx, int cy,
                                              int rad, bit f, bit l, bit q);
        vtx_beat_t v;
        v.point_x = COORD_BITS'(px);
        v.point_y = COORD_BITS'(py);
        v.wall_x = COORD_BITS'(wx);
        v.wall_y = COORD_BITS'(wy);
        v.circle_x = COORD_BITS'(cx);
        v.circle_y = COORD_BITS'(cy);
        v.circle_radius = (COORD_BITS-1)'(rad);
        v.first_point = f;
        v.last_point = l;
        v.query_end = q;
        return v;
    endfunction

    initial
    begin
        int maxc, minc, maxr;
        int cx, cy, rad, n;
        vtx_beat_t v;
        maxc = (1 << (COORD_BITS - 1)) - 1;
        minc = -(1 << (COORD_BITS - 1));
        maxr = (1 << (COORD_BITS - 1)) - 1;
        errors = 0;
        stimulus_done = 1'b0;
        calm_phase = 1'b0;
        start_x = '0;
        start_y = '0;
        prev_x = '0;
        prev_y = '0;
        running_hit = 1'b0;

        // Directed part. A vertex without a first mark right after reset chains from the origin.
        vertex_queue.push_back(make_vertex(256, 0, 0, 0, 0, 0, 128, 0, 0, 0));
        // Tangent edge: the line y = 256 just touches a circle of radius 256.
        vertex_queue.push_back(make_vertex(-512, 256, 0, 0, 0, 0, 256, 1, 0, 0));
        vertex_queue.push_back(make_vertex(512, 256, 0, 0, 0, 0, 256, 0, 0, 0));
        // Zero-length edge, then a closing edge.
        vertex_queue.push_back(make_vertex(512, 256, 0, 0, 0, 0, 256, 0, 1, 1));
        // Single-vertex polygon right on the circle: no hit.
        vertex_queue.push_back(make_vertex(256, 0, 0, 0, 0, 0, 256, 1, 1, 1));
        // Edge wholly inside the circle, then crossing it.
        vertex_queue.push_back(make_vertex(-10, 0, 0, 0, 0, 0, 1000, 1, 0, 0));
        vertex_queue.push_back(make_vertex(10, 0, 0, 0, 0, 0, 1000, 0, 0, 0));
        vertex_queue.push_back(make_vertex(5000, 0, 0, 0, 0, 0, 1000, 0, 1, 1));
        // Extremes of every field: full-scale corners, wall sums beyond the coordinate range.
        vertex_queue.push_back(make_vertex(maxc, maxc, maxc, maxc, minc, minc, maxr, 1, 0, 0));
        vertex_queue.push_back(make_vertex(minc, minc, minc, minc, maxc, maxc, maxr, 0, 0, 0));
        vertex_queue.push_back(make_vertex(maxc, minc, minc, maxc, 0, 0, 0, 0, 1, 0));
        vertex_queue.push_back(make_vertex(minc, maxc, maxc, minc, maxc, minc, maxr, 1, 0, 0));
        vertex_queue.push_back(make_vertex(maxc, maxc, maxc, maxc, maxc, maxc, 0, 0, 1, 1));
        // Zero radius with a vertex exactly on the centre.
        vertex_queue.push_back(make_vertex(0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        vertex_queue.push_back(make_vertex(100, 0, -100, 0, 0, 0, 0, 0, 1, 1));
        // Polygon far from the circle: a miss.
        vertex_queue.push_back(make_vertex(9000, 9000, 0, 0, 0, 0, 100, 1, 0, 0));
        vertex_queue.push_back(make_vertex(9100, 9000, 0, 0, 0, 0, 100, 0, 0, 0));
        vertex_queue.push_back(make_vertex(9000, 9100, 0, 0, 0, 0, 100, 0, 1, 1));

        // Random part: mostly well-formed queries of a few polygons each.
        while (vertex_queue.size() < 1050)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // Noise: fully random fields and marks.
                v = make_vertex(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
                v.point_x = rand_coord();
                v.point_y = rand_coord();
                v.wall_x = rand_coord();
                v.wall_y = rand_coord();
                v.circle_x = rand_coord();
                v.circle_y = rand_coord();
                v.circle_radius = (COORD_BITS-1)'($urandom);
                v.first_point = $urandom_range(0, 1);
                v.last_point = $urandom_range(0, 1);
                v.query_end = $urandom_range(0, 1);
                vertex_queue.push_back(v);
            end
            else
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    cx = $signed(rand_coord()) / 2;
                    cy = $signed(rand_coord()) / 2;
                    rad = $urandom_range(0, 1 << 20);
                end
                else
                begin
                    cx = $signed($urandom_range(0, 40000)) - 20000;
                    cy = $signed($urandom_range(0, 40000)) - 20000;
                    rad = $urandom_range(0, 3000);
                end
                n = $urandom_range(1, 3);
                for (int p = 0; p < n; p++)
                    add_polygon($urandom_range(1, 6), cx, cy, rad, p == n - 1);
            end
        end
        stimulus_done = 1'b1;
    end

    // Reset, then the long calm stretch and the receiver hold-off are timed from here.
    initial
    begin
        rst_n = 1'b0;
        hold_off = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (400) @(posedge clk);
        calm_phase = 1'b1;
        repeat (3000) @(posedge clk);
        calm_phase = 1'b0;
        repeat (2000) @(posedge clk);
        // Hold the result side for a long stretch while vertices keep being offered.
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
    end

    // Driver: offers the head of the queue, idling at random about a third of the time.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx.valid <= 1'b0;
            vtx.data <= '0;
        end
        else if (!vtx.valid || vtx.ready)
        begin
            if (vtx.valid)
                expected_hits.push_back(predict_hit(vtx.data));
            if (vertex_queue.size() > 0 && (calm_phase || $urandom_range(0, 99) >= 32))
            begin
                vtx.valid <= 1'b1;
                vtx.data <= vertex_queue.pop_front();
            end
            else
                vtx.valid <= 1'b0;
        end
    end

    // Monitor: checks each accepted hit beat against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        hit_beat_t want;
        if (!rst_n)
            hit.ready <= 1'b0;
        else
        begin
            if (hit.valid && hit.ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $error("hit beat with no vertex outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (hit.data.edge_hit !== want.edge_hit)
                    begin
                        $error("edge_hit expected %0b actual %0b", want.edge_hit,
                               hit.data.edge_hit);
                        errors++;
                    end
                    if (hit.data.hit_so_far !== want.hit_so_far)
                    begin
                        $error("hit_so_far expected %0b actual %0b", want.hit_so_far,
                               hit.data.hit_so_far);
                        errors++;
                    end
                    if (hit.data.result_last !== want.result_last)
                    begin
                        $error("result_last expected %0b actual %0b", want.result_last,
                               hit.data.result_last);
                        errors++;
                    end
                end
            end
            if (hold_off)
                hit.ready <= 1'b0;
            else
                hit.ready <= calm_phase || $urandom_range(0, 99) >= 32;
        end
    end

    // End of run: drain, let the block settle, then give the verdict; a timeout fails.
    initial
    begin
        cycle_count = 0;
        fork
            begin
                wait (stimulus_done);
                while (vertex_queue.size() > 0 || vtx.valid || expected_hits.size() > 0)
                    @(posedge clk);
                repeat (100) @(posedge clk);
                if (errors == 0)
                    $display("[circle_polygon_edge_hit_unit] OK");
                else
                    $display("[circle_polygon_edge_hit_unit] ERROR");
            end
            begin
                // Timeout for the whole run, allowing for the slowest vertex beats and random stalls on both sides.
                while (cycle_count < 400000)
                begin
                    @(posedge clk);
                    cycle_count++;
                end
                $display("[circle_polygon_edge_hit_unit] ERROR");
            end
        join_any
        $finish;
    end

endmodule

>>> files.f
sv/cpeh_pkg.sv
sv/cpeh_stream_if.sv
sv/circle_polygon_edge_hit_unit.sv
verif/tb_circle_polygon_edge_hit_unit.sv
